[sv/thb_pkg.sv]
// ----------------------------------------------------------------------------
// thb_pkg
// Types and constants shared by the TDC hit event builder: item layouts,
// stage records, item kind codes and the fixed field constants.
// ----------------------------------------------------------------------------
package thb_pkg;

  // Item kind codes on the input channel.
  typedef enum logic [1:0] {
    KIND_HIT      = 2'd0,
    KIND_TABLE_WR = 2'd1,
    KIND_FLUSH    = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 1'b1;

  // Field codes and channel geometry.
  localparam logic [1:0] EDGE_LEADING   = 2'd1;
  localparam logic [7:0] HIT_FIRST      = 8'd1;
  localparam logic [6:0] MASK_CHANNELS  = 7'd64;
  localparam logic [6:0] MIRROR_BASE    = 7'd64;
  localparam int         SIDE_CHANNELS  = 32;

  // Signed 32-bit limits.
  localparam logic signed [31:0] S32_MAX_C = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN_C = 32'sh8000_0000;

  // Input item.
  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        event_number;
    logic [6:0]         channel;
    logic [23:0]        raw_time;
    logic [1:0]         edge_code;
    logic [7:0]         hit_number;
    logic signed [31:0] offset_value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [31:0]        done_event_number;
    logic [1:0]         trigger_category;
    logic               coincidence;
    logic               has_fastest;
    logic [6:0]         fastest_channel;
    logic signed [31:0] fastest_time;
    logic [9:0]         fastest_raw_index;
    logic               fastest_paired;
    logic [10:0]        multi_hit_count;
    logic [10:0]        clean_count;
    logic [10:0]        raw_count;
  } out_item_t;

  // Item in the table read stage.
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] event_number;
    logic [6:0]  channel;
    logic [23:0] raw_time;
    logic [1:0]  edge_code;
    logic [7:0]  hit_number;
    logic        use_offset;
  } calib_req_t;

  // Item in the event update stage, carrying its calibrated time.
  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic [31:0]        event_number;
    logic [6:0]         channel;
    logic               clean;
    logic               multi;
    logic signed [31:0] cal_time;
  } calib_res_t;

endpackage

[sv/thb_if.sv]
// ----------------------------------------------------------------------------
// thb_if
// Valid/ready channels of the TDC hit event builder: one for input items and
// one for event summaries.
// ----------------------------------------------------------------------------
interface thb_in_if;
  import thb_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface thb_out_if;
  import thb_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/tdc_hit_event_builder_core.sv]
// ----------------------------------------------------------------------------
// tdc_hit_event_builder_core
// Builds per-event summaries from a stream of TDC hits, offset table writes
// and flushes.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless stalled; the offset table is read in
// the accept cycle and the event state is updated from the calibration
// register in one pass. A summary enters the output register when the item
// closing its event (a hit of a new event number, or a flush) is processed.
// The input stalls only while a new summary waits on a full output register.
// Reset clears all offset entries at once through per-entry flags; no sweep.
// ----------------------------------------------------------------------------
module tdc_hit_event_builder_core #(
  parameter int NUM_CHANNELS       = 64,
  parameter int MAX_HITS_PER_EVENT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  thb_in_if.sink                        in_ch,
  thb_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [thb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wr_data
);
  import thb_pkg::*;

  localparam int AW = $clog2(NUM_CHANNELS);

  in_item_t           item;
  logic               stall, accept, in_table, ram_wr, ram_rd;
  logic [6:0]         ch_m1;
  logic signed [31:0] offset_data;
  logic               offset_written;
  calib_req_t         s1_r, s1_nxt;
  calib_res_t         s2;
  logic               acc_out_valid;
  out_item_t          acc_out_data;

  assign item         = in_ch.data;
  assign in_ch.ready  = !stall;
  assign accept       = in_ch.valid && !stall;
  assign ch_m1        = item.channel - 7'd1;
  assign in_table     = (item.channel >= 7'd1) && (item.channel <= 7'(NUM_CHANNELS));
  assign ram_wr       = accept && (item.kind == KIND_TABLE_WR) && in_table;
  assign ram_rd       = accept && (item.kind == KIND_HIT) && in_table;

  // Offset table.
  thb_offset_ram #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .AW           (AW)
  ) u_ram (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (ram_wr),
    .rd_en      (ram_rd),
    .addr       (ch_m1[AW-1:0]),
    .wr_data    (item.offset_value),
    .rd_data    (offset_data),
    .rd_written (offset_written)
  );

  // Table read stage: holds the item while its offset is read.
  always_comb begin
    s1_nxt.valid        = accept;
    s1_nxt.kind         = item.kind;
    s1_nxt.event_number = item.event_number;
    s1_nxt.channel      = item.channel;
    s1_nxt.raw_time     = item.raw_time;
    s1_nxt.edge_code    = item.edge_code;
    s1_nxt.hit_number   = item.hit_number;
    s1_nxt.use_offset   = in_table;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (!stall) begin
      s1_r <= s1_nxt;
    end
  end

  // Calibration stage.
  thb_calib u_calib (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (!stall),
    .s1             (s1_r),
    .offset_data    (offset_data),
    .offset_written (offset_written),
    .s2             (s2)
  );

  // Event accumulation and summary output.
  thb_event_acc #(
    .MAX_HITS_PER_EVENT (MAX_HITS_PER_EVENT)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s2          (s2),
    .out_ready   (out_ch.ready),
    .stall       (stall),
    .out_valid   (acc_out_valid),
    .out_data    (acc_out_data)
  );

  assign out_ch.valid = acc_out_valid;
  assign out_ch.data  = acc_out_data;

  // A stall freezes both pipeline stages.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> ($stable(s1_r) && $stable(s2)))
    else $error("pipeline stage changed during a stall");

  // A channel side can only be seen when a fastest hit exists.
  a_side_needs_fastest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.trigger_category != 2'b00) |-> out_ch.data.has_fastest)
    else $error("side bit set without a fastest hit");

  // A coincidence needs a channel on each side.
  a_coin_both_sides: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.coincidence) |-> (out_ch.data.trigger_category == 2'b11))
    else $error("coincidence without both sides");

  // Without a clean hit the fastest fields are zero.
  a_no_fastest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.data.has_fastest) |->
      (out_ch.data.fastest_channel == 7'd0 && out_ch.data.fastest_time == 32'sd0 &&
       !out_ch.data.fastest_paired))
    else $error("fastest fields set without a fastest hit");
endmodule

[sv/thb_offset_ram.sv]
// ----------------------------------------------------------------------------
// thb_offset_ram
// Per-channel offset table: a single-port synchronous memory with registered
// read data and one written flag per entry, so users can zero unwritten ones.
// ----------------------------------------------------------------------------
module thb_offset_ram #(
  parameter int NUM_CHANNELS = 64,
  parameter int AW           = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic                    rd_en,
  input  logic [AW-1:0]           addr,
  input  logic signed [31:0]      wr_data,
  output logic signed [31:0]      rd_data,
  output logic                    rd_written
);
  logic signed [31:0]      mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] written_r;
  logic signed [31:0]      rd_data_r;
  logic                    rd_written_r;

  // Memory array: one access per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // Written flags, cleared together at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written_r <= written_r[addr];
      end
    end
  end

  assign rd_data    = rd_data_r;
  assign rd_written = rd_written_r;
endmodule

[sv/thb_calib.sv]
// ----------------------------------------------------------------------------
// thb_calib
// Calibration stage: subtracts the channel offset from the raw time in Q4,
// saturates to signed 32 bits and classifies the hit.
// ----------------------------------------------------------------------------
module thb_calib (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  thb_pkg::calib_req_t s1,
  input  logic signed [31:0]  offset_data,
  input  logic                offset_written,
  output thb_pkg::calib_res_t s2
);
  import thb_pkg::*;

  logic signed [31:0] offset;
  logic signed [33:0] scaled;
  logic signed [33:0] offset_ext;
  logic signed [33:0] diff;
  logic signed [31:0] cal_time;
  calib_res_t         s2_r;
  calib_res_t         s2_nxt;

  // Offset of channels outside the table, or never written, is zero.
  assign offset     = (s1.use_offset && offset_written) ? offset_data : '0;
  assign scaled     = $signed({6'd0, s1.raw_time, 4'd0});
  assign offset_ext = {{2{offset[31]}}, offset};
  assign diff       = scaled - offset_ext;

  // Saturate to the signed 32-bit range when the top bits disagree.
  always_comb begin
    if (diff[33:31] == 3'b000 || diff[33:31] == 3'b111) begin
      cal_time = diff[31:0];
    end else if (diff[33]) begin
      cal_time = S32_MIN_C;
    end else begin
      cal_time = S32_MAX_C;
    end
  end

  always_comb begin
    s2_nxt.valid        = s1.valid;
    s2_nxt.kind         = s1.kind;
    s2_nxt.event_number = s1.event_number;
    s2_nxt.channel      = s1.channel;
    s2_nxt.clean        = (s1.hit_number == HIT_FIRST) && (s1.edge_code == EDGE_LEADING);
    s2_nxt.multi        = (s1.hit_number > HIT_FIRST);
    s2_nxt.cal_time     = cal_time;
  end

  // Stage register; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (advance) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;
endmodule

[sv/thb_event_acc.sv]
// ----------------------------------------------------------------------------
// thb_event_acc
// Event accumulator: window test, channel mask, earliest hit and saturating
// counters of the open event, plus the summary output register.
// ----------------------------------------------------------------------------
module thb_event_acc #(
  parameter int MAX_HITS_PER_EVENT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [thb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wr_data,
  input  thb_pkg::calib_res_t           s2,
  input  logic                          out_ready,
  output logic                          stall,
  output logic                          out_valid,
  output thb_pkg::out_item_t            out_data
);
  import thb_pkg::*;

  localparam int CW = $clog2(MAX_HITS_PER_EVENT + 1);
  localparam int IW = $clog2(MAX_HITS_PER_EVENT);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_HITS_PER_EVENT);
  localparam logic [IW-1:0] IDX_MAX = IW'(MAX_HITS_PER_EVENT - 1);

  // Configuration and event state.
  logic signed [31:0] win_low_r, win_high_r;
  logic [31:0]        cur_event_r, cur_event_nxt;
  logic               open_r, open_nxt;
  logic [63:0]        mask_r, mask_nxt;
  logic signed [31:0] best_time_r, best_time_nxt;
  logic [6:0]         best_ch_r, best_ch_nxt;
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic               best_valid_r, best_valid_nxt;
  logic [CW-1:0]      cnt_multi_r, cnt_multi_nxt;
  logic [CW-1:0]      cnt_clean_r, cnt_clean_nxt;
  logic [CW-1:0]      cnt_raw_r, cnt_raw_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               is_hit, is_flush, boundary, emit, proc, in_window, in_mask;
  logic [6:0]         ch_m1, mirror_idx;
  logic signed [31:0] t;
  logic [63:0]        base_mask;
  logic signed [31:0] base_time;
  logic [6:0]         base_ch;
  logic [IW-1:0]      base_idx;
  logic               base_valid;
  logic [CW-1:0]      base_multi, base_clean, base_raw;
  logic [IW-1:0]      raw_index;
  logic [SIDE_CHANNELS-1:0] mirror_bits;
  out_item_t          summary;

  assign is_hit   = s2.valid && (s2.kind == KIND_HIT);
  assign is_flush = s2.valid && (s2.kind == KIND_FLUSH);
  assign boundary = open_r && (s2.event_number != cur_event_r);
  assign emit     = (is_flush && open_r) || (is_hit && boundary);

  // Hold the pipeline only when a summary meets a full output register.
  assign stall = out_valid_r && !out_ready && emit;
  assign proc  = s2.valid && !stall;

  assign t          = s2.cal_time;
  assign in_window  = (t >= win_low_r) && (t <= win_high_r);
  assign ch_m1      = s2.channel - 7'd1;
  assign in_mask    = (s2.channel >= 7'd1) && (s2.channel <= MASK_CHANNELS);

  // A hit of a new event starts from the cleared state.
  always_comb begin
    if (boundary) begin
      base_mask  = '0;
      base_time  = S32_MAX_C;
      base_ch    = '0;
      base_idx   = '0;
      base_valid = 1'b0;
      base_multi = '0;
      base_clean = '0;
      base_raw   = '0;
    end else begin
      base_mask  = mask_r;
      base_time  = best_time_r;
      base_ch    = best_ch_r;
      base_idx   = best_idx_r;
      base_valid = best_valid_r;
      base_multi = cnt_multi_r;
      base_clean = cnt_clean_r;
      base_raw   = cnt_raw_r;
    end
  end

  assign raw_index = (base_raw >= CNT_MAX) ? IDX_MAX : base_raw[IW-1:0];

  // Next event state.
  always_comb begin
    cur_event_nxt  = cur_event_r;
    open_nxt       = open_r;
    mask_nxt       = mask_r;
    best_time_nxt  = best_time_r;
    best_ch_nxt    = best_ch_r;
    best_idx_nxt   = best_idx_r;
    best_valid_nxt = best_valid_r;
    cnt_multi_nxt  = cnt_multi_r;
    cnt_clean_nxt  = cnt_clean_r;
    cnt_raw_nxt    = cnt_raw_r;
    if (proc && is_flush) begin
      open_nxt       = 1'b0;
      mask_nxt       = '0;
      best_time_nxt  = S32_MAX_C;
      best_ch_nxt    = '0;
      best_idx_nxt   = '0;
      best_valid_nxt = 1'b0;
      cnt_multi_nxt  = '0;
      cnt_clean_nxt  = '0;
      cnt_raw_nxt    = '0;
    end else if (proc && is_hit) begin
      cur_event_nxt  = s2.event_number;
      open_nxt       = 1'b1;
      mask_nxt       = base_mask;
      best_time_nxt  = base_time;
      best_ch_nxt    = base_ch;
      best_idx_nxt   = base_idx;
      best_valid_nxt = base_valid;
      cnt_multi_nxt  = base_multi;
      cnt_clean_nxt  = base_clean;
      cnt_raw_nxt    = (base_raw < CNT_MAX) ? base_raw + 1'b1 : base_raw;
      if (s2.multi && base_multi < CNT_MAX) begin
        cnt_multi_nxt = base_multi + 1'b1;
      end
      if (s2.clean && in_window) begin
        if (base_clean < CNT_MAX) begin
          cnt_clean_nxt = base_clean + 1'b1;
        end
        if (in_mask) begin
          mask_nxt[ch_m1[5:0]] = 1'b1;
        end
        // Strictly earlier wins, so the first hit keeps a tie.
        if (!base_valid || t < base_time) begin
          best_valid_nxt = 1'b1;
          best_time_nxt  = t;
          best_ch_nxt    = s2.channel;
          best_idx_nxt   = raw_index;
        end
      end
    end
  end

  // Summary of the open event, taken from the current state.
  always_comb begin
    for (int i = 0; i < SIDE_CHANNELS; i++) begin
      mirror_bits[i] = mask_r[63 - i];
    end
  end

  assign mirror_idx = MIRROR_BASE - best_ch_r;

  always_comb begin
    summary.done_event_number = cur_event_r;
    summary.trigger_category  = {|mask_r[63:32], |mask_r[31:0]};
    summary.coincidence       = |(mask_r[31:0] & mirror_bits);
    summary.has_fastest       = best_valid_r;
    summary.fastest_channel   = best_valid_r ? best_ch_r : '0;
    summary.fastest_time      = best_valid_r ? best_time_r : '0;
    summary.fastest_raw_index = best_valid_r ? 10'(best_idx_r) : '0;
    summary.fastest_paired    = best_valid_r && (best_ch_r >= 7'd1) &&
                                (best_ch_r <= MASK_CHANNELS) && mask_r[mirror_idx[5:0]];
    summary.multi_hit_count   = 11'(cnt_multi_r);
    summary.clean_count       = 11'(cnt_clean_r);
    summary.raw_count         = 11'(cnt_raw_r);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r  <= S32_MIN_C;
      win_high_r <= S32_MAX_C;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_WINDOW_LOW) begin
        win_low_r <= cfg_wr_data;
      end
      if (cfg_index == CFG_WINDOW_HIGH) begin
        win_high_r <= cfg_wr_data;
      end
    end
  end

  // Event state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_event_r  <= '0;
      open_r       <= 1'b0;
      mask_r       <= '0;
      best_time_r  <= S32_MAX_C;
      best_ch_r    <= '0;
      best_idx_r   <= '0;
      best_valid_r <= 1'b0;
      cnt_multi_r  <= '0;
      cnt_clean_r  <= '0;
      cnt_raw_r    <= '0;
    end else begin
      cur_event_r  <= cur_event_nxt;
      open_r       <= open_nxt;
      mask_r       <= mask_nxt;
      best_time_r  <= best_time_nxt;
      best_ch_r    <= best_ch_nxt;
      best_idx_r   <= best_idx_nxt;
      best_valid_r <= best_valid_nxt;
      cnt_multi_r  <= cnt_multi_nxt;
      cnt_clean_r  <= cnt_clean_nxt;
      cnt_raw_r    <= cnt_raw_nxt;
    end
  end

  // Output register for finished summaries.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && emit) begin
      out_valid_r <= 1'b1;
      out_data_r  <= summary;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

[verif/tdc_hit_event_builder_core_tb.sv]
// ----------------------------------------------------------------------------
// tdc_hit_event_builder_core_tb
// Self-checking testbench for the TDC hit event builder. A behavioural model
// of the event builder predicts one summary per closed event. Every summary
// the block emits is compared field by field with the oldest prediction.
// Directed cases come first, then window boundaries, counter saturation and
// a long random stream of well-formed events mixed with noise. Both channel
// ends idle in random patterns throughout.
// ----------------------------------------------------------------------------
module tdc_hit_event_builder_core_tb;
  import thb_pkg::*;

  localparam int NUM_CH       = 64;
  localparam int MAX_HITS     = 1024;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT   = 4000;

  // Kind code that the block has no use for.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wr_data;

  thb_in_if  in_if ();
  thb_out_if out_if ();

  tdc_hit_event_builder_core #(
    .NUM_CHANNELS       (NUM_CH),
    .MAX_HITS_PER_EVENT (MAX_HITS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Event builder model state.
  logic signed [31:0] win_lo;
  logic signed [31:0] win_hi;
  logic signed [31:0] offsets [NUM_CH];
  logic [31:0]        cur_evt;
  bit                 evt_open;
  logic [63:0]        clean_mask;
  logic signed [31:0] best_t;
  logic [6:0]         best_ch;
  logic [9:0]         best_idx;
  bit                 best_ok;
  logic [10:0]        n_multi;
  logic [10:0]        n_clean;
  logic [10:0]        n_raw;

  out_item_t expected_summaries [$];
  out_item_t want;
  int        n_errors = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  int        gap_cycles = 0;
  logic [31:0] last_evt = '0;
  logic [6:0]  last_ch = 7'd1;

  // Clears the per-event part of the model.
  function automatic void clear_event();
    clean_mask = '0;
    best_t     = S32_MAX_C;
    best_ch    = '0;
    best_idx   = '0;
    best_ok    = 1'b0;
    n_multi    = '0;
    n_clean    = '0;
    n_raw      = '0;
  endfunction

  // Summary of the event that is currently open.
  function automatic out_item_t summarise_event();
    out_item_t s;
    s = '0;
    s.done_event_number = cur_evt;
    s.trigger_category  = {|clean_mask[63:32], |clean_mask[31:0]};
    for (int c = 1; c <= SIDE_CHANNELS; c++)
      if (clean_mask[c-1] && clean_mask[64-c]) s.coincidence = 1'b1;
    if (best_ok) begin
      s.has_fastest       = 1'b1;
      s.fastest_channel   = best_ch;
      s.fastest_time      = best_t;
      s.fastest_raw_index = best_idx;
      if (best_ch >= 1 && best_ch <= 64)
        s.fastest_paired = clean_mask[64 - int'(best_ch)];
    end
    s.multi_hit_count = n_multi;
    s.clean_count     = n_clean;
    s.raw_count       = n_raw;
    return s;
  endfunction

  // Appends the summary of the open event to the expected queue.
  function automatic void queue_summary();
    expected_summaries.insert(expected_summaries.size(), summarise_event());
  endfunction

  // Applies one accepted item to the model and queues any summary it closes.
  task automatic predict_item(input in_item_t it);
    longint     cal;
    longint     off;
    logic [9:0] idx;
    case (it.kind)
      KIND_TABLE_WR: begin
        if (it.channel >= 1 && it.channel <= NUM_CH)
          offsets[it.channel - 7'd1] = it.offset_value;
      end
      KIND_FLUSH: begin
        if (evt_open) begin
          queue_summary();
          evt_open = 1'b0;
          clear_event();
        end
      end
      KIND_HIT: begin
        if (evt_open && it.event_number != cur_evt) begin
          queue_summary();
          clear_event();
        end
        cur_evt  = it.event_number;
        evt_open = 1'b1;
        idx = (n_raw > MAX_HITS - 1) ? 10'(MAX_HITS - 1) : n_raw[9:0];
        if (n_raw < MAX_HITS) n_raw++;
        if (it.hit_number > HIT_FIRST && n_multi < MAX_HITS) n_multi++;
        if (it.hit_number == HIT_FIRST && it.edge_code == EDGE_LEADING) begin
          off = 0;
          if (it.channel >= 1 && it.channel <= NUM_CH)
            off = longint'(offsets[it.channel - 7'd1]);
          cal = longint'(it.raw_time);
          cal = cal * 16 - off;
          if (cal > S32_MAX_C) cal = S32_MAX_C;
          if (cal < S32_MIN_C) cal = S32_MIN_C;
          if (cal >= win_lo && cal <= win_hi) begin
            if (n_clean < MAX_HITS) n_clean++;
            if (it.channel >= 1 && it.channel <= MASK_CHANNELS)
              clean_mask[it.channel - 7'd1] = 1'b1;
            if (!best_ok || cal < best_t) begin
              best_ok  = 1'b1;
              best_t   = cal[31:0];
              best_ch  = it.channel;
              best_idx = idx;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t make_hit(logic [31:0] evt, logic [6:0] ch, logic [23:0] raw,
                                        logic [1:0] edge_v, logic [7:0] hnum);
    in_item_t it;
    it.kind         = KIND_HIT;
    it.event_number = evt;
    it.channel      = ch;
    it.raw_time     = raw;
    it.edge_code    = edge_v;
    it.hit_number   = hnum;
    it.offset_value = $urandom;
    return it;
  endfunction

  // Table writes, flushes and unused kinds; fields they ignore are random.
  function automatic in_item_t make_ctl(logic [1:0] kind, logic [6:0] ch,
                                        logic signed [31:0] offset);
    in_item_t it;
    it.kind         = kind;
    it.event_number = $urandom;
    it.channel      = ch;
    it.raw_time     = 24'($urandom);
    it.edge_code    = 2'($urandom);
    it.hit_number   = 8'($urandom);
    it.offset_value = offset;
    return it;
  endfunction

  // Sends one item in bursts with random gaps, then updates the model.
  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_cycles > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap_cycles) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    predict_item(it);
  endtask

  // Holds the sender off until every predicted summary has arrived.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both window registers; only called while the block is idle.
  task automatic set_window(input logic signed [31:0] lo, input logic signed [31:0] hi);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_WINDOW_LOW;
    cfg_wr_data <= lo;
    @(posedge clk);
    cfg_index   <= CFG_WINDOW_HIGH;
    cfg_wr_data <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_lo = lo;
    win_hi = hi;
  endtask

  task automatic test_directed_cases();
    // Flush with nothing open, and an unused kind: neither gives a summary.
    send_item(make_ctl(KIND_FLUSH, 7'd0, 32'sd0));
    send_item(make_ctl(KIND_UNUSED, 7'd5, 32'sd77));
    // Offset writes at the extremes, and writes outside the table.
    send_item(make_ctl(KIND_TABLE_WR, 7'd1, S32_MAX_C));
    send_item(make_ctl(KIND_TABLE_WR, 7'd64, S32_MIN_C));
    send_item(make_ctl(KIND_TABLE_WR, 7'd0, 32'sd1234));
    send_item(make_ctl(KIND_TABLE_WR, 7'd65, 32'sd85));
    send_item(make_ctl(KIND_TABLE_WR, 7'd127, -32'sd9));
    // Event zero: mirrored pair at both ends, overflow, channels off the mask.
    send_item(make_hit(32'd0, 7'd1, 24'd0, EDGE_LEADING, HIT_FIRST));
    send_item(make_hit(32'd0, 7'd64, 24'hFFFFFF, EDGE_LEADING, HIT_FIRST));
    send_item(make_hit(32'd0, 7'd0, 24'd5, EDGE_LEADING, HIT_FIRST));
    send_item(make_hit(32'd0, 7'd100, 24'd0, EDGE_LEADING, HIT_FIRST));
    send_item(make_hit(32'd0, 7'd3, 24'd7, EDGE_LEADING, 8'd0));
    send_item(make_hit(32'd0, 7'd3, 24'd7, EDGE_LEADING, 8'd255));
    send_item(make_hit(32'd0, 7'd4, 24'd7, 2'd0, HIT_FIRST));
    send_item(make_hit(32'd0, 7'd4, 24'd7, 2'd2, HIT_FIRST));
    send_item(make_hit(32'd0, 7'd4, 24'd7, 2'd3, HIT_FIRST));
    // A table write in the middle of an event leaves it open.
    send_item(make_ctl(KIND_TABLE_WR, 7'd2, 32'sd16));
    // Largest event number; a tie on time goes to the first hit.
    send_item(make_hit(32'hFFFF_FFFF, 7'd2, 24'd1, EDGE_LEADING, HIT_FIRST));
    send_item(make_hit(32'hFFFF_FFFF, 7'd63, 24'd0, EDGE_LEADING, HIT_FIRST));
    send_item(make_hit(32'hFFFF_FFFF, 7'd64, 24'd0, EDGE_LEADING, HIT_FIRST));
    send_item(make_ctl(KIND_FLUSH, 7'd0, 32'sd0));
    send_item(make_ctl(KIND_FLUSH, 7'd0, 32'sd0));
    // An event with no clean hit.
    send_item(make_hit(32'd0, 7'd10, 24'd3, 2'd0, HIT_FIRST));
    // A channel off the mask wins as the fastest and is not paired.
    send_item(make_hit(32'd7, 7'd127, 24'd0, EDGE_LEADING, HIT_FIRST));
    send_item(make_hit(32'd7, 7'd5, 24'd10, EDGE_LEADING, HIT_FIRST));
    send_item(make_ctl(KIND_FLUSH, 7'd0, 32'sd0));
  endtask

  task automatic test_window_edges();
    // A single accepted value: only the hit exactly on it is kept.
    wait_idle();
    set_window(32'sd1000, 32'sd1000);
    send_item(make_ctl(KIND_TABLE_WR, 7'd10, 32'sd8));
    send_item(make_ctl(KIND_TABLE_WR, 7'd11, 32'sd9));
    send_item(make_ctl(KIND_TABLE_WR, 7'd12, 32'sd7));
    send_item(make_hit(32'd20, 7'd11, 24'd63, EDGE_LEADING, HIT_FIRST));
    send_item(make_hit(32'd20, 7'd12, 24'd63, EDGE_LEADING, HIT_FIRST));
    send_item(make_hit(32'd20, 7'd10, 24'd63, EDGE_LEADING, HIT_FIRST));
    send_item(make_ctl(KIND_FLUSH, 7'd0, 32'sd0));
    // Only the saturated top value passes.
    wait_idle();
    set_window(S32_MAX_C, S32_MAX_C);
    send_item(make_hit(32'd21, 7'd1, 24'd0, EDGE_LEADING, HIT_FIRST));
    send_item(make_hit(32'd21, 7'd64, 24'hFFFFFF, EDGE_LEADING, HIT_FIRST));
    send_item(make_ctl(KIND_FLUSH, 7'd0, 32'sd0));
    // Bottom value only: the lowest reachable time lies just above it.
    wait_idle();
    set_window(S32_MIN_C, S32_MIN_C);
    send_item(make_hit(32'd22, 7'd1, 24'd0, EDGE_LEADING, HIT_FIRST));
    send_item(make_ctl(KIND_FLUSH, 7'd0, 32'sd0));
    // Low bound above the high bound rejects everything.
    wait_idle();
    set_window(32'sd5, -32'sd5);
    send_item(make_hit(32'd23, 7'd100, 24'd0, EDGE_LEADING, HIT_FIRST));
    send_item(make_ctl(KIND_FLUSH, 7'd0, 32'sd0));
    wait_idle();
    set_window(S32_MIN_C, S32_MAX_C);
  endtask

  task automatic test_counter_saturation();
    // More multi hits and clean hits than the counters can hold; the last
    // clean hit is the earliest, so its raw index saturates as well.
    for (int i = 0; i < MAX_HITS + 6; i++)
      send_item(make_hit(32'h1234_5678, 7'd20, 24'd99, EDGE_LEADING, 8'd2));
    for (int i = 0; i < MAX_HITS + 6; i++)
      send_item(make_hit(32'h1234_5678, 7'd20, 24'(5000 - i), EDGE_LEADING, HIT_FIRST));
    send_item(make_ctl(KIND_FLUSH, 7'd0, 32'sd0));
  endtask

  function automatic in_item_t random_hit(logic [31:0] evt);
    int         r;
    logic [6:0] ch;
    logic [23:0] raw;
    logic [1:0] edge_v;
    logic [7:0] hnum;
    r = $urandom_range(0, 99);
    if (r < 70) ch = 7'($urandom_range(1, 64));
    else if (r < 85 && last_ch >= 1 && last_ch <= 64) ch = 7'd65 - last_ch;
    else ch = 7'($urandom_range(0, 127));
    last_ch = ch;
    r = $urandom_range(0, 99);
    if (r < 50) raw = 24'($urandom_range(0, 4095));
    else if (r < 80) raw = 24'($urandom_range(0, 15));
    else raw = 24'($urandom);
    edge_v = ($urandom_range(0, 4) != 0) ? EDGE_LEADING : 2'($urandom_range(0, 3));
    hnum   = ($urandom_range(0, 4) != 0) ? HIT_FIRST : 8'($urandom_range(0, 255));
    return make_hit(evt, ch, raw, edge_v, hnum);
  endfunction

  function automatic in_item_t random_table_write();
    int                 r;
    logic [6:0]         ch;
    logic signed [31:0] offset;
    ch = ($urandom_range(0, 6) != 0) ? 7'($urandom_range(1, 64)) : 7'($urandom_range(0, 127));
    r = $urandom_range(0, 9);
    if (r < 6) offset = $urandom_range(0, 65535) - 32768;
    else if (r < 8) offset = $urandom;
    else offset = r[0] ? S32_MAX_C : S32_MIN_C;
    return make_ctl(KIND_TABLE_WR, ch, offset);
  endfunction

  // Mostly whole events with random hits; the rest flushes, table writes,
  // unused kinds and lone hits of arbitrary events.
  task automatic random_burst_stream(input int n_items, input bit pause_midway);
    int          sent;
    int          roll;
    int          n_hits;
    logic [31:0] evt;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (pause_midway && sent >= n_items / 2) begin
        pause_midway = 1'b0;
        wait_idle();
      end
      if (roll < 75) begin
        roll = $urandom_range(0, 9);
        if (roll < 6) evt = last_evt + 1;
        else if (roll < 8) evt = last_evt;
        else evt = $urandom;
        last_evt = evt;
        n_hits = $urandom_range(1, 10);
        repeat (n_hits) begin
          send_item(random_hit(evt));
          sent++;
          if ($urandom_range(0, 19) == 0) begin
            send_item(random_table_write());
            sent++;
          end
        end
      end else if (roll < 85) begin
        send_item(make_ctl(KIND_FLUSH, 7'($urandom), $urandom));
        sent++;
      end else if (roll < 94) begin
        send_item(random_table_write());
        sent++;
      end else if (roll < 97) begin
        send_item(make_ctl(KIND_UNUSED, 7'($urandom), $urandom));
      end else begin
        send_item(random_hit($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random_stream();
    int lo;
    // Full range, a narrow window around typical times, and the extremes.
    random_burst_stream(130, 1'b1);
    wait_idle();
    lo = $urandom_range(0, 20000) - 10000;
    set_window(lo, lo + $urandom_range(20000, 90000));
    random_burst_stream(130, 1'b0);
    wait_idle();
    set_window(32'sd0, S32_MAX_C);
    random_burst_stream(130, 1'b0);
    wait_idle();
    set_window(S32_MAX_C, S32_MAX_C);
    random_burst_stream(60, 1'b0);
    wait_idle();
    set_window($urandom_range(1, 1000), -32'sd1);
    random_burst_stream(60, 1'b0);
    wait_idle();
    set_window(S32_MIN_C, S32_MAX_C);
    random_burst_stream(130, 1'b0);
    send_item(make_ctl(KIND_FLUSH, 7'd0, 32'sd0));
  endtask

  // Receiver stalls on a repeating pattern that is redrawn after each random
  // span, with some stretches that never stall.
  initial begin : receiver_pattern
    int period;
    int stall_len;
    int phase;
    int span;
    out_if.ready <= 1'b0;
    period    = 1;
    stall_len = 0;
    phase     = 0;
    span      = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span      = $urandom_range(32, 256);
        period    = $urandom_range(2, 20);
        stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, period - 1);
        phase     = 0;
      end
      out_if.ready <= (phase >= stall_len);
      phase = (phase + 1) % period;
      span--;
    end
  end

  // Compares each accepted summary with the oldest prediction.
  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_summaries.size() == 0) begin
        $display("%0t: summary for event %0h arrived with none expected, expected none, actual %0h",
                 $time, out_if.data.done_event_number, out_if.data);
        n_errors++;
      end else begin
        want = expected_summaries.pop_front();
        check_field("done_event_number", want.done_event_number,
                    out_if.data.done_event_number);
        check_field("trigger_category", 32'(want.trigger_category),
                    32'(out_if.data.trigger_category));
        check_field("coincidence", 32'(want.coincidence), 32'(out_if.data.coincidence));
        check_field("has_fastest", 32'(want.has_fastest), 32'(out_if.data.has_fastest));
        check_field("fastest_channel", 32'(want.fastest_channel),
                    32'(out_if.data.fastest_channel));
        check_field("fastest_time", want.fastest_time, out_if.data.fastest_time);
        check_field("fastest_raw_index", 32'(want.fastest_raw_index),
                    32'(out_if.data.fastest_raw_index));
        check_field("fastest_paired", 32'(want.fastest_paired),
                    32'(out_if.data.fastest_paired));
        check_field("multi_hit_count", 32'(want.multi_hit_count),
                    32'(out_if.data.multi_hit_count));
        check_field("clean_count", 32'(want.clean_count), 32'(out_if.data.clean_count));
        check_field("raw_count", 32'(want.raw_count), 32'(out_if.data.raw_count));
      end
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Reset, then each test in turn, then the final verdict.
  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= CFG_WINDOW_LOW;
    cfg_wr_data <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    win_lo   = S32_MIN_C;
    win_hi   = S32_MAX_C;
    cur_evt  = '0;
    evt_open = 1'b0;
    foreach (offsets[i]) offsets[i] = '0;
    clear_event();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_window_edges();
    test_counter_saturation();
    test_random_stream();
    wait_idle();

    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
